@@ rtl/core/lbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants of the LED blink controller
// Beat formats, command and mode codes, status codes and register defaults.
// ----------------------------------------------------------------------------
package lbc_pkg;

	// default geometry
	localparam int NUM_PORTS_DEF     = 3;
	localparam int PINS_PER_PORT_DEF = 16;

	// pin slots are laid out as port*16+pin
	localparam int PORT_STRIDE = 16;
	localparam int SLOT_W      = 64;
	localparam int LEVEL_W     = 48;

	// command codes
	localparam logic [2:0] CMD_CLAIM_LED  = 3'd0;
	localparam logic [2:0] CMD_CLAIM_GPIO = 3'd1;
	localparam logic [2:0] CMD_RELEASE    = 3'd2;
	localparam logic [2:0] CMD_SET_MODE   = 3'd3;
	localparam logic [2:0] CMD_TICK       = 3'd4;

	// led modes
	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_ON     = 2'd1;
	localparam logic [1:0] MODE_SINGLE = 2'd2;
	localparam logic [1:0] MODE_CONT   = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_ADDR = 2'd1;
	localparam logic [1:0] STAT_IN_USE   = 2'd2;

	// blink period register reset value
	localparam logic [15:0] PERIOD_RST = 16'd1000;

	// command beat
	typedef struct packed {
		logic [2:0] command;
		logic [1:0] port_index;
		logic [3:0] pin_index;
		logic [1:0] led_mode;
		logic       on_polarity;
	} lbc_cmd_t;

	// result beat
	typedef struct packed {
		logic [LEVEL_W-1:0] pin_levels;
		logic [1:0]         status;
		logic               timer_running;
	} lbc_res_t;

	// broadcast from control to every pin cell
	typedef struct packed {
		logic [2:0] command;
		logic [1:0] led_mode;
		logic       on_polarity;
		logic       expire;
		logic       phase;
	} lbc_bcast_t;

endpackage

@@ rtl/core/lbc_cell.sv @@
// ----------------------------------------------------------------------------
// lbc_cell: state of one pin
// Holds in-use, led flag, on level, led mode and driven level of one pin,
// and passes the "some pin blinked" flag on to its neighbor.
// ----------------------------------------------------------------------------
module lbc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sel,
	input  lbc_pkg::lbc_bcast_t bc,
	input  logic              any_in,
	output logic              any_out,
	output logic              used,
	output logic              level
);
	import lbc_pkg::*;

	logic       used_q;
	logic       is_led_q;
	logic       on_q;
	logic [1:0] mode_q;
	logic       level_q;
	logic       scan;
	logic       blink;

	// expiry scan only touches used led pins
	assign scan    = bc.expire & used_q & is_led_q;
	assign blink   = scan & ((mode_q == MODE_SINGLE) | (mode_q == MODE_CONT));
	assign any_out = any_in | blink;
	assign used    = used_q;
	assign level   = level_q;

	// pin state update; a tick that addresses this pin still takes the expiry scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= 1'b0;
			is_led_q <= 1'b0;
			on_q     <= 1'b0;
			mode_q   <= MODE_OFF;
			level_q  <= 1'b0;
		end else if (scan) begin
			case (mode_q)
				MODE_SINGLE: begin
					level_q <= on_q;
					mode_q  <= MODE_OFF;
				end
				MODE_CONT: level_q <= bc.phase;
				MODE_ON:   level_q <= level_q;
				default:   level_q <= ~on_q;
			endcase
		end else if (sel) begin
			case (bc.command)
				CMD_CLAIM_LED, CMD_CLAIM_GPIO: begin
					if (!used_q) begin
						used_q   <= 1'b1;
						is_led_q <= (bc.command == CMD_CLAIM_LED);
						if (bc.command == CMD_CLAIM_LED)
							on_q <= bc.on_polarity;
					end
				end
				CMD_RELEASE: begin
					used_q <= 1'b0;
				end
				CMD_SET_MODE: begin
					mode_q <= bc.led_mode;
					if (bc.led_mode == MODE_ON)
						level_q <= on_q;
					else if (bc.led_mode == MODE_OFF)
						level_q <= ~on_q;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/core/lbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbc_ctrl: period timer, blink phase and status
// Counts base ticks, raises the expiry pulse for the cell row and forms the
// status of each accepted beat.
// ----------------------------------------------------------------------------
module lbc_ctrl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [2:0]  command,
	input  logic [1:0]  led_mode,
	input  logic        addr_valid,
	input  logic        addr_used,
	input  logic        any_blink,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        expire,
	output logic        phase_next,
	output logic        running,
	output logic [1:0]  status
);
	import lbc_pkg::*;

	logic [15:0] period_q;
	logic [15:0] count_q;
	logic        running_q;
	logic        phase_q;
	logic [1:0]  status_q;
	logic        tick;
	logic [16:0] count_inc;
	logic        start;

	// tick and expiry; a period of zero expires on every tick
	assign tick       = accept & (command == CMD_TICK) & running_q;
	assign count_inc  = {1'b0, count_q} + 17'd1;
	assign expire     = tick & (count_inc >= {1'b0, period_q});
	assign phase_next = ~phase_q;
	assign start      = accept & addr_valid & (command == CMD_SET_MODE) & ~running_q &
		((led_mode == MODE_SINGLE) | (led_mode == MODE_CONT));

	assign running = running_q;
	assign status  = status_q;

	// period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			period_q <= PERIOD_RST;
		else if (cfg_we)
			period_q <= cfg_wdata;
	end

	// timer and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			running_q <= 1'b0;
			phase_q   <= 1'b1;
		end else if (expire) begin
			count_q   <= '0;
			running_q <= any_blink;
			phase_q   <= ~phase_q;
		end else if (tick) begin
			count_q <= count_inc[15:0];
		end else if (start) begin
			count_q   <= '0;
			running_q <= 1'b1;
		end
	end

	// status of the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			status_q <= STAT_OK;
		else if (accept) begin
			if ((command <= CMD_SET_MODE) && !addr_valid)
				status_q <= STAT_BAD_ADDR;
			else if (((command == CMD_CLAIM_LED) || (command == CMD_CLAIM_GPIO)) && addr_used)
				status_q <= STAT_IN_USE;
			else
				status_q <= STAT_OK;
		end
	end

	// count restarts after every expiry
	a_expire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		expire |=> (count_q == '0))
		else $error("period count not cleared after expiry");

	// phase only moves on expiry
	a_phase_on_expire: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(phase_q) |-> $past(expire))
		else $error("blink phase changed without expiry");

	// an idle timer does not count
	a_idle_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!running_q && !start) |=> (count_q == $past(count_q)))
		else $error("period count moved while timer idle");

	// status never takes the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		status_q != 2'd3)
		else $error("status holds an unused code");

endmodule

@@ rtl/core/multi_pin_led_blink_controller.sv @@
// ----------------------------------------------------------------------------
// multi_pin_led_blink_controller: command-driven LED and GPIO pin table
// Pin cells in a row, a period timer and a registered result beat.
// ----------------------------------------------------------------------------
// For each command beat the pin table, the blink timer and the status are
// updated at the accepting edge and the result beat appears in the result
// register in the next cycle. A new command is taken in every cycle in which
// the result register is empty or its beat is taken, so the sustained rate is
// one beat per clock. Every pin lives in its own cell, so a period expiry
// rewrites the levels of all used LED pins in that same clock; the only long
// path is the blink flag rippling through the cell row into the timer.
// ----------------------------------------------------------------------------
module multi_pin_led_blink_controller #(
	parameter int NUM_PORTS     = lbc_pkg::NUM_PORTS_DEF,
	parameter int PINS_PER_PORT = lbc_pkg::PINS_PER_PORT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  lbc_pkg::lbc_cmd_t cmd_beat,
	output logic              res_valid,
	input  logic              res_stall,
	output lbc_pkg::lbc_res_t res_beat,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata
);
	import lbc_pkg::*;

	localparam int NCELL = NUM_PORTS * PINS_PER_PORT;

	logic              accept;
	logic              res_valid_q;
	logic              addr_valid;
	logic              addr_used;
	logic              expire;
	logic              phase_next;
	logic              running;
	logic [1:0]        status;
	lbc_bcast_t        bc;
	logic [NCELL-1:0]  hit;
	logic [NCELL-1:0]  cell_used;
	logic [NCELL-1:0]  cell_level;
	logic [NCELL:0]    any_chain;
	logic [SLOT_W-1:0] level_slots;

	// handshake
	assign cmd_stall = res_valid_q & res_stall;
	assign accept    = cmd_valid & ~cmd_stall;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (accept)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	// address decode
	assign addr_valid = (32'(cmd_beat.port_index) < NUM_PORTS) &&
		(32'(cmd_beat.pin_index) < PINS_PER_PORT);
	assign addr_used  = |(hit & cell_used);

	// broadcast to the cells
	always_comb begin
		bc.command     = cmd_beat.command;
		bc.led_mode    = cmd_beat.led_mode;
		bc.on_polarity = cmd_beat.on_polarity;
		bc.expire      = expire;
		bc.phase       = phase_next;
	end

	assign any_chain[0] = 1'b0;

	// row of pin cells
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		localparam int P = i / PINS_PER_PORT;
		localparam int Q = i % PINS_PER_PORT;

		assign hit[i] = (32'(cmd_beat.port_index) == P) && (32'(cmd_beat.pin_index) == Q);

		lbc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.sel     (accept & addr_valid & hit[i]),
			.bc      (bc),
			.any_in  (any_chain[i]),
			.any_out (any_chain[i+1]),
			.used    (cell_used[i]),
			.level   (cell_level[i])
		);
	end

	// place cell levels at port*16+pin
	always_comb begin
		level_slots = '0;
		for (int i = 0; i < NCELL; i++)
			level_slots[(i / PINS_PER_PORT) * PORT_STRIDE + (i % PINS_PER_PORT)] = cell_level[i];
	end

	// timer, phase and status
	lbc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (cmd_beat.command),
		.led_mode   (cmd_beat.led_mode),
		.addr_valid (addr_valid),
		.addr_used  (addr_used),
		.any_blink  (any_chain[NCELL]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.expire     (expire),
		.phase_next (phase_next),
		.running    (running),
		.status     (status)
	);

	// result beat; cell state only moves on an accepted beat
	always_comb begin
		res_beat.pin_levels    = level_slots[LEVEL_W-1:0];
		res_beat.status        = status;
		res_beat.timer_running = running;
	end

endmodule
